// ===== hdl/gno_pkg.sv =====
// Shared types, constants and arithmetic helpers for the gradient noise block.
`default_nettype none
package gno_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int TBL_DEPTH  = 256;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int TBL_W      = 8;
  localparam int MAX_OCT    = 8;
  localparam int OCT_W      = 4;
  localparam int OIDX_W     = $clog2(MAX_OCT);
  localparam int PERS_W     = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = PERS_W;
  localparam int OUT_W      = 18;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int MUL_W      = 25;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int VAL_W      = 22;
  localparam int CRD_W      = FRAC_BITS + 1;
  localparam int ACC_W      = 44;
  localparam int NUM_W      = ACC_W + 1;
  localparam int ASUM_W     = PERS_W + OIDX_W;
  localparam int REM_W      = ASUM_W + 1;
  localparam int DCNT_W     = $clog2(NUM_W + 1);
  localparam int HASH_W     = 4;

  localparam logic [PERS_W-1:0] AMP_ONE = PERS_W'(1 << FRAC_BITS);
  localparam logic [OCT_W-1:0] OCT_MIN_CNT = OCT_W'(1);
  localparam logic [OCT_W-1:0] OCT_MAX_CNT = OCT_W'(MAX_OCT);
  localparam logic signed [VAL_W-1:0] V_ONE = VAL_W'(1 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] V_TEN = VAL_W'(10 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] V_FIFTEEN = VAL_W'(15 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] V_SIX = VAL_W'(6);
  localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(1 << (OUT_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVES = 1'b0,
    CFG_PERSIST = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    K_LOAD = 1'b0,
    K_EVAL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [TBL_AW-1:0]          tidx;
    logic [TBL_W-1:0]           tval;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  cz;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } qpush_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // round to nearest, ties up, drop the fraction bits of a product
  function automatic logic signed [VAL_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + P_HALF;
    return VAL_W'(s >>> FRAC_BITS);
  endfunction

  function automatic logic signed [VAL_W-1:0] grad(
    input logic [HASH_W-1:0]      h,
    input logic signed [CRD_W-1:0] x,
    input logic signed [CRD_W-1:0] y,
    input logic signed [CRD_W-1:0] z
  );
    logic signed [CRD_W-1:0] u;
    logic signed [CRD_W-1:0] v;
    logic signed [VAL_W-1:0] su;
    logic signed [VAL_W-1:0] sv;
    u = h[3] ? y : x;
    if (h[3:2] == 2'b00) begin
      v = y;
    end else if (h[3:2] == 2'b11 && !h[0]) begin
      v = x;
    end else begin
      v = z;
    end
    su = h[0] ? -VAL_W'(u) : VAL_W'(u);
    sv = h[1] ? -VAL_W'(v) : VAL_W'(v);
    return su + sv;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gno_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module gno_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]              rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/gno_front.sv =====
// Front end: accepts commands and classifies them into queue entries.
`default_nettype none
module gno_front (
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_action,
  input  wire logic [gno_pkg::TBL_AW-1:0]    in_table_index,
  input  wire logic [gno_pkg::TBL_W-1:0]     in_table_value,
  input  wire logic signed [gno_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic signed [gno_pkg::COORD_W-1:0] in_coord_y,
  input  wire logic signed [gno_pkg::COORD_W-1:0] in_coord_z,
  input  wire gno_pkg::qstat_t               qstat,
  output gno_pkg::qpush_t                    qpush
);

  gno_pkg::kind_t kind;

  assign busy = qstat.full;
  assign kind = in_action ? gno_pkg::K_EVAL : gno_pkg::K_LOAD;

  always_comb begin
    qpush.push      = start && !qstat.full;
    qpush.item      = '0;
    qpush.item.kind = kind;
    unique case (kind)
      gno_pkg::K_LOAD: begin
        qpush.item.tidx = in_table_index;
        qpush.item.tval = in_table_value;
      end
      gno_pkg::K_EVAL: begin
        qpush.item.cx = in_coord_x;
        qpush.item.cy = in_coord_y;
        qpush.item.cz = in_coord_z;
      end
      default: qpush.item = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/gno_fifo.sv =====
// Short command queue between the front end and the evaluation core.
`default_nettype none
module gno_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gno_pkg::qpush_t qpush,
  input  wire logic            pop,
  output gno_pkg::item_t       head,
  output gno_pkg::qstat_t      qstat
);

  gno_pkg::item_t                   mem_r [gno_pkg::FIFO_DEPTH];
  logic [gno_pkg::FIFO_AW-1:0]      wp_r;
  logic [gno_pkg::FIFO_AW-1:0]      rp_r;
  logic [gno_pkg::FIFO_AW:0]        cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == (gno_pkg::FIFO_AW+1)'(gno_pkg::FIFO_DEPTH));
  assign do_push     = qpush.push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= qpush.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (gno_pkg::FIFO_AW+1)'(do_push) - (gno_pkg::FIFO_AW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gno_core.sv =====
// Evaluation core: table writes, octave sequencer, shared multiplier and divider.
`default_nettype none
module gno_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gno_pkg::item_t                    head,
  input  wire gno_pkg::qstat_t                   qstat,
  output logic                                   pop,
  input  wire logic [gno_pkg::OCT_W-1:0]         octave_count,
  input  wire logic [gno_pkg::PERS_W-1:0]        persistence,
  output logic                                   out_valid,
  output logic signed [gno_pkg::OUT_W-1:0]       out_noise_value
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_OCT  = 14'b00000000000010,
    ST_FMUL = 14'b00000000000100,
    ST_FACC = 14'b00000000001000,
    ST_HREQ = 14'b00000000010000,
    ST_HGET = 14'b00000000100000,
    ST_BMUL = 14'b00000001000000,
    ST_BACC = 14'b00000010000000,
    ST_AMUL = 14'b00000100000000,
    ST_AACC = 14'b00001000000000,
    ST_PMUL = 14'b00010000000000,
    ST_PACC = 14'b00100000000000,
    ST_DIV  = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_t;

  localparam logic [3:0] HS_CELL0 = 4'd0;
  localparam logic [3:0] HS_A     = 4'd1;
  localparam logic [3:0] HS_A1    = 4'd2;
  localparam logic [3:0] HS_CELL1 = 4'd3;
  localparam logic [3:0] HS_B     = 4'd4;
  localparam logic [3:0] HS_B1    = 4'd5;
  localparam logic [3:0] HS_C0    = 4'd6;
  localparam logic [3:0] HS_C1    = 4'd7;
  localparam logic [3:0] HS_C2    = 4'd8;
  localparam logic [3:0] HS_C3    = 4'd9;
  localparam logic [3:0] HS_C4    = 4'd10;
  localparam logic [3:0] HS_C5    = 4'd11;
  localparam logic [3:0] HS_C6    = 4'd12;
  localparam logic [3:0] HS_C7    = 4'd13;
  localparam logic [3:0] HS_DONE  = 4'd14;

  localparam int AW = gno_pkg::TBL_AW;
  localparam int FB = gno_pkg::FRAC_BITS;
  localparam int VW = gno_pkg::VAL_W;

  state_t                              state_r;
  logic signed [gno_pkg::COORD_W-1:0]  crd_r [3];
  logic [gno_pkg::OIDX_W-1:0]          oct_r;
  logic [gno_pkg::OCT_W-1:0]           noct_r;
  logic [gno_pkg::PERS_W-1:0]          pers_r;
  logic [gno_pkg::PERS_W-1:0]          amp_r;
  logic [gno_pkg::ASUM_W-1:0]          asum_r;
  logic signed [gno_pkg::ACC_W-1:0]    total_r;
  logic [2:0][FB-1:0]                  frac_r;
  logic [2:0][AW-1:0]                  cell_r;
  logic [2:0][gno_pkg::PERS_W-1:0]     fade_r;
  logic [1:0]                          fj_r;
  logic [1:0]                          fax_r;
  logic signed [VW-1:0]                facc_r;
  logic [3:0]                          hs_r;
  logic [AW-1:0]                       a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [VW-1:0]                st_r [4];
  logic [1:0]                          blc_r;
  logic [1:0]                          blk_r;
  logic signed [gno_pkg::PROD_W-1:0]   p_r;
  logic [gno_pkg::NUM_W-1:0]           num_r;
  logic [gno_pkg::ASUM_W-1:0]          rem_r;
  logic [gno_pkg::DCNT_W-1:0]          dcnt_r;
  logic                                neg_r;
  logic [gno_pkg::TBL_DEPTH-1:0]       vld_r;
  logic                                rd_vld_r;
  logic [AW-1:0]                       rd_addr_r;
  logic                                out_valid_r;
  logic signed [gno_pkg::OUT_W-1:0]    out_noise_r;

  logic signed [gno_pkg::MUL_W-1:0]    mul_a;
  logic signed [gno_pkg::MUL_W-1:0]    mul_b;
  logic signed [VW-1:0]                rnd_v;
  logic signed [VW-1:0]                fr;
  logic [AW-1:0]                       haddr;
  logic [gno_pkg::TBL_W-1:0]           ram_q;
  logic [gno_pkg::TBL_W-1:0]           tbl_d;
  logic                                tbl_we;
  logic [2:0]                          ci;
  logic signed [gno_pkg::CRD_W-1:0]    cx, cy, cz;
  logic signed [VW-1:0]                gval;
  logic [1:0]                          nb;
  logic signed [VW:0]                  bdiff;
  logic signed [VW-1:0]                bres;
  logic [gno_pkg::COORD_W-1:0]         shs [3];
  logic [gno_pkg::REM_W-1:0]           remsh;
  logic                                ge;
  logic [gno_pkg::ACC_W-1:0]           mag;
  logic [gno_pkg::OCT_W-1:0]           noct_c;

  assign pop    = (state_r == ST_IDLE) && !qstat.empty;
  assign tbl_we = pop && (head.kind == gno_pkg::K_LOAD);
  assign tbl_d  = rd_vld_r ? ram_q : rd_addr_r;
  assign rnd_v  = gno_pkg::rnd(p_r);
  assign fr     = rnd_v + ((fj_r == 2'd0) ? gno_pkg::V_TEN : '0);
  assign ci     = 3'(hs_r - HS_C0);
  assign bdiff  = (VW+1)'(st_r[0]) - (VW+1)'(st_r[1]);
  assign bres   = st_r[1] + rnd_v;
  assign remsh  = {rem_r, num_r[gno_pkg::NUM_W-1]};
  assign ge     = (remsh >= {1'b0, asum_r});
  assign mag    = total_r[gno_pkg::ACC_W-1] ? gno_pkg::ACC_W'(-total_r)
                                            : gno_pkg::ACC_W'(total_r);
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shs[i] = gno_pkg::COORD_W'(crd_r[i]) << oct_r;
    end
  end

  always_comb begin
    if (octave_count < gno_pkg::OCT_MIN_CNT) begin
      noct_c = gno_pkg::OCT_MIN_CNT;
    end else if (octave_count > gno_pkg::OCT_MAX_CNT) begin
      noct_c = gno_pkg::OCT_MAX_CNT;
    end else begin
      noct_c = octave_count;
    end
  end

  always_comb begin
    cx = ci[0] ? gno_pkg::CRD_W'(signed'({1'b0, frac_r[0]}) - gno_pkg::CRD_W'(1 << FB))
               : signed'({1'b0, frac_r[0]});
    cy = ci[1] ? gno_pkg::CRD_W'(signed'({1'b0, frac_r[1]}) - gno_pkg::CRD_W'(1 << FB))
               : signed'({1'b0, frac_r[1]});
    cz = ci[2] ? gno_pkg::CRD_W'(signed'({1'b0, frac_r[2]}) - gno_pkg::CRD_W'(1 << FB))
               : signed'({1'b0, frac_r[2]});
    gval = gno_pkg::grad(tbl_d[gno_pkg::HASH_W-1:0], cx, cy, cz);
    if (!ci[0]) begin
      nb = 2'd0;
    end else if (!ci[1]) begin
      nb = 2'd1;
    end else if (!ci[2]) begin
      nb = 2'd2;
    end else begin
      nb = 2'd3;
    end
  end

  always_comb begin
    unique case (hs_r)
      HS_CELL0: haddr = cell_r[0];
      HS_A:     haddr = a_r;
      HS_A1:    haddr = a_r + 1'b1;
      HS_CELL1: haddr = cell_r[0] + 1'b1;
      HS_B:     haddr = b_r;
      HS_B1:    haddr = b_r + 1'b1;
      HS_C0:    haddr = aa_r;
      HS_C1:    haddr = ba_r;
      HS_C2:    haddr = ab_r;
      HS_C3:    haddr = bb_r;
      HS_C4:    haddr = aa_r + 1'b1;
      HS_C5:    haddr = ba_r + 1'b1;
      HS_C6:    haddr = ab_r + 1'b1;
      HS_C7:    haddr = bb_r + 1'b1;
      default:  haddr = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_FMUL: begin
        mul_a = gno_pkg::MUL_W'(signed'({1'b0, frac_r[fax_r]}));
        mul_b = gno_pkg::MUL_W'(facc_r);
      end
      ST_BMUL: begin
        mul_a = gno_pkg::MUL_W'(signed'({1'b0, fade_r[blk_r]}));
        mul_b = gno_pkg::MUL_W'(bdiff);
      end
      ST_AMUL: begin
        mul_a = gno_pkg::MUL_W'(st_r[0]);
        mul_b = gno_pkg::MUL_W'(signed'({1'b0, amp_r}));
      end
      ST_PMUL: begin
        mul_a = gno_pkg::MUL_W'(signed'({1'b0, amp_r}));
        mul_b = gno_pkg::MUL_W'(signed'({1'b0, pers_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gno_ram #(
    .W (gno_pkg::TBL_W),
    .D (gno_pkg::TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (head.tidx),
    .wdata (head.tval),
    .raddr (haddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    p_r       <= gno_pkg::PROD_W'(mul_a) * gno_pkg::PROD_W'(mul_b);
    rd_vld_r  <= vld_r[haddr];
    rd_addr_r <= haddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (tbl_we) begin
      vld_r[head.tidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_OUT);
      unique case (state_r)
        ST_IDLE: begin
          if (pop && head.kind == gno_pkg::K_EVAL) begin
            crd_r[0] <= head.cx;
            crd_r[1] <= head.cy;
            crd_r[2] <= head.cz;
            oct_r    <= '0;
            noct_r   <= noct_c;
            pers_r   <= (persistence > gno_pkg::AMP_ONE) ? gno_pkg::AMP_ONE : persistence;
            amp_r    <= gno_pkg::AMP_ONE;
            asum_r   <= '0;
            total_r  <= '0;
            state_r  <= ST_OCT;
          end
        end
        ST_OCT: begin
          for (int i = 0; i < 3; i++) begin
            frac_r[i] <= shs[i][FB-1:0];
            cell_r[i] <= shs[i][FB+AW-1:FB];
          end
          fj_r    <= '0;
          fax_r   <= '0;
          facc_r  <= gno_pkg::V_SIX * VW'(shs[0][FB-1:0]) - gno_pkg::V_FIFTEEN;
          state_r <= ST_FMUL;
        end
        ST_FMUL: state_r <= ST_FACC;
        ST_FACC: begin
          if (fj_r == 2'd3) begin
            if (fr < 0) begin
              fade_r[fax_r] <= '0;
            end else if (fr > gno_pkg::V_ONE) begin
              fade_r[fax_r] <= gno_pkg::AMP_ONE;
            end else begin
              fade_r[fax_r] <= fr[gno_pkg::PERS_W-1:0];
            end
            fj_r <= '0;
            if (fax_r == 2'd2) begin
              hs_r    <= HS_CELL0;
              state_r <= ST_HREQ;
            end else begin
              fax_r   <= fax_r + 1'b1;
              facc_r  <= gno_pkg::V_SIX * VW'(frac_r[fax_r + 1'b1]) - gno_pkg::V_FIFTEEN;
              state_r <= ST_FMUL;
            end
          end else begin
            facc_r  <= fr;
            fj_r    <= fj_r + 1'b1;
            state_r <= ST_FMUL;
          end
        end
        ST_HREQ: state_r <= ST_HGET;
        ST_HGET: begin
          state_r <= (hs_r >= HS_C0 && nb != 2'd0) ? ST_BMUL : ST_HREQ;
          hs_r    <= hs_r + 1'b1;
          unique case (hs_r)
            HS_CELL0: a_r  <= tbl_d + cell_r[1];
            HS_A:     aa_r <= tbl_d + cell_r[2];
            HS_A1:    ab_r <= tbl_d + cell_r[2];
            HS_CELL1: b_r  <= tbl_d + cell_r[1];
            HS_B:     ba_r <= tbl_d + cell_r[2];
            HS_B1:    bb_r <= tbl_d + cell_r[2];
            default: begin
              st_r[0] <= gval;
              st_r[1] <= st_r[0];
              st_r[2] <= st_r[1];
              st_r[3] <= st_r[2];
              blc_r   <= nb;
              blk_r   <= '0;
            end
          endcase
        end
        ST_BMUL: state_r <= ST_BACC;
        ST_BACC: begin
          st_r[0] <= bres;
          st_r[1] <= st_r[2];
          st_r[2] <= st_r[3];
          blc_r   <= blc_r - 1'b1;
          blk_r   <= blk_r + 1'b1;
          if (blc_r != 2'd1) begin
            state_r <= ST_BMUL;
          end else if (hs_r == HS_DONE) begin
            state_r <= ST_AMUL;
          end else begin
            state_r <= ST_HREQ;
          end
        end
        ST_AMUL: state_r <= ST_AACC;
        ST_AACC: begin
          total_r <= total_r + gno_pkg::ACC_W'(p_r);
          asum_r  <= asum_r + gno_pkg::ASUM_W'(amp_r);
          state_r <= ST_PMUL;
        end
        ST_PMUL: state_r <= ST_PACC;
        ST_PACC: begin
          amp_r <= rnd_v[gno_pkg::PERS_W-1:0];
          oct_r <= oct_r + 1'b1;
          if (gno_pkg::OCT_W'(oct_r) + 1'b1 == noct_r) begin
            num_r   <= gno_pkg::NUM_W'(mag) + gno_pkg::NUM_W'(asum_r >> 1);
            rem_r   <= '0;
            neg_r   <= total_r[gno_pkg::ACC_W-1];
            dcnt_r  <= gno_pkg::DCNT_W'(gno_pkg::NUM_W);
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_OCT;
          end
        end
        ST_DIV: begin
          rem_r  <= ge ? gno_pkg::ASUM_W'(remsh - {1'b0, asum_r})
                       : remsh[gno_pkg::ASUM_W-1:0];
          num_r  <= {num_r[gno_pkg::NUM_W-2:0], ge};
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == gno_pkg::DCNT_W'(1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (neg_r) begin
            out_noise_r <= (num_r > gno_pkg::Q_NEG_LIM) ? gno_pkg::OUT_MIN
                                                        : -gno_pkg::OUT_W'(num_r);
          end else begin
            out_noise_r <= (num_r > gno_pkg::Q_POS_LIM) ? gno_pkg::OUT_MAX
                                                        : gno_pkg::OUT_W'(num_r);
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gradient_noise_3d_octaves.sv =====
// Top level of the fractal 3D gradient noise block.
// An evaluate command runs its octaves in turn, then one division; the octave
// time is set by the shared 25x25 multiplier that runs the fade, blend and
// weighting steps one product at a time and by the single read port of the
// permutation RAM (14 reads per octave), and the tail by a one-bit-per-cycle
// 45-bit divider. A table load writes the RAM when it is popped. Commands enter
// a two-beat queue; busy is high while it is full. Each result is shown for one
// cycle on out_valid and cannot be stalled.
`default_nettype none
module gradient_noise_3d_octaves (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_action,
  input  wire logic [gno_pkg::TBL_AW-1:0]          in_table_index,
  input  wire logic [gno_pkg::TBL_W-1:0]           in_table_value,
  input  wire logic signed [gno_pkg::COORD_W-1:0]  in_coord_x,
  input  wire logic signed [gno_pkg::COORD_W-1:0]  in_coord_y,
  input  wire logic signed [gno_pkg::COORD_W-1:0]  in_coord_z,
  output logic                                     out_valid,
  output logic signed [gno_pkg::OUT_W-1:0]         out_noise_value,
  input  wire logic                                cfg_we,
  input  wire logic [gno_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gno_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [gno_pkg::OCT_W-1:0]  octave_count_r;
  logic [gno_pkg::PERS_W-1:0] persistence_r;
  gno_pkg::qpush_t            qpush;
  gno_pkg::qstat_t            qstat;
  gno_pkg::item_t             head;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= gno_pkg::OCT_W'(1);
      persistence_r  <= gno_pkg::PERS_W'(1 << (gno_pkg::FRAC_BITS - 1));
    end else if (cfg_we) begin
      unique case (gno_pkg::cfg_idx_t'(cfg_index))
        gno_pkg::CFG_OCTAVES: octave_count_r <= cfg_wdata[gno_pkg::OCT_W-1:0];
        gno_pkg::CFG_PERSIST: persistence_r  <= cfg_wdata[gno_pkg::PERS_W-1:0];
        default: ;
      endcase
    end
  end

  gno_front u_front (
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .qstat          (qstat),
    .qpush          (qpush)
  );

  gno_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  gno_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .qstat           (qstat),
    .pop             (pop),
    .octave_count    (octave_count_r),
    .persistence     (persistence_r),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

endmodule
`default_nettype wire

// ===== hdl/gno_checker.sv =====
// Port-level checks on the noise block, bound to the top level.
`default_nettype none
module gno_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("strobe or busy after reset");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("queue filled without a command beat");

endmodule

bind gradient_noise_3d_octaves gno_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire
